[src/ttsf_pkg.sv]
// Shared types, constants and helper functions for the temperature display block.
package ttsf_pkg;

	localparam logic [15:0] KELVIN_OFFSET = 16'd27315;
	localparam logic [15:0] WRAP_1X = 16'd10000;
	localparam logic [15:0] WRAP_2X = 16'd20000;
	localparam logic [15:0] WRAP_3X = 16'd30000;

	localparam logic [13:0] WEIGHT_THOU = 14'd1000;
	localparam logic [13:0] WEIGHT_HUND = 14'd100;
	localparam logic [13:0] WEIGHT_TENS = 14'd10;

	localparam logic [7:0] CMD_DISPLAY = 8'h40;
	localparam logic [7:0] CMD_ADDR = 8'hc0;
	localparam logic [7:0] COLON_BIT = 8'h80;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam logic [0:0] REG_COLON_ENABLE = 1'b0;

	typedef struct packed {
		logic [3:0] thou;
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] units;
	} digits_t;

	typedef struct packed {
		logic [3:0] digit;
		logic [13:0] rem;
	} split_t;

	// Peel off one decimal digit of weight from a value below ten times weight.
	function automatic split_t split_digit(input logic [13:0] val, input logic [13:0] weight);
		split_t res;
		logic [3:0] cnt;
		logic [13:0] prod;
		cnt = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			if ({4'd0, val} >= (18'(k) * {4'd0, weight})) begin
				cnt = cnt + 4'd1;
			end
		end
		prod = 14'({10'd0, cnt} * weight);
		res.digit = cnt;
		res.rem = val - prod;
		return res;
	endfunction

	function automatic logic [7:0] seg_pattern(input logic [3:0] d);
		logic [7:0] pat;
		case (d)
			4'd0: pat = 8'h3f;
			4'd1: pat = 8'h06;
			4'd2: pat = 8'h5b;
			4'd3: pat = 8'h4f;
			4'd4: pat = 8'h66;
			4'd5: pat = 8'h6d;
			4'd6: pat = 8'h7d;
			4'd7: pat = 8'h07;
			4'd8: pat = 8'h7f;
			4'd9: pat = 8'h6f;
			default: pat = 8'h00;
		endcase
		return pat;
	endfunction

endpackage

[src/ttsf_digit_pipe.sv]
// Five-stage pipeline from raw sensor bytes to four decimal digits.
module ttsf_digit_pipe
	import ttsf_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    reading_low,
	input  logic [7:0]    reading_high,
	output logic          out_valid,
	input  logic          out_ready,
	output digits_t       out_digits
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	logic [15:0] temp_s1;
	logic [13:0] mod_s2;
	logic [3:0]  thou_s3;
	logic [9:0]  rem_s3;
	logic [3:0]  thou_s4, hund_s4;
	logic [6:0]  rem_s4;
	digits_t     digits_s5;

	logic [15:0] twice;
	logic [15:0] temp_c;
	logic [13:0] mod_c;
	split_t      sp3, sp4, sp5;

	assign rdy5 = !valid_s5 || out_ready;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	// Stage 1: form the word, scale and drop the offset, clamp at zero.
	assign twice = {reading_high[6:0], reading_low, 1'b0};
	assign temp_c = (twice > KELVIN_OFFSET) ? (twice - KELVIN_OFFSET) : 16'd0;

	// Stage 2: keep the lowest four digits; the value stays below forty thousand.
	always_comb begin
		if (temp_s1 >= WRAP_3X) begin
			mod_c = 14'(temp_s1 - WRAP_3X);
		end else if (temp_s1 >= WRAP_2X) begin
			mod_c = 14'(temp_s1 - WRAP_2X);
		end else if (temp_s1 >= WRAP_1X) begin
			mod_c = 14'(temp_s1 - WRAP_1X);
		end else begin
			mod_c = temp_s1[13:0];
		end
	end

	// Stages 3 to 5: one decimal digit off the top in each.
	assign sp3 = split_digit(mod_s2, WEIGHT_THOU);
	assign sp4 = split_digit({4'd0, rem_s3}, WEIGHT_HUND);
	assign sp5 = split_digit({7'd0, rem_s4}, WEIGHT_TENS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			temp_s1 <= temp_c;
		end
		if (rdy2 && valid_s1) begin
			mod_s2 <= mod_c;
		end
		if (rdy3 && valid_s2) begin
			thou_s3 <= sp3.digit;
			rem_s3  <= sp3.rem[9:0];
		end
		if (rdy4 && valid_s3) begin
			thou_s4 <= thou_s3;
			hund_s4 <= sp4.digit;
			rem_s4  <= sp4.rem[6:0];
		end
		if (rdy5 && valid_s4) begin
			digits_s5.thou  <= thou_s4;
			digits_s5.hund  <= hund_s4;
			digits_s5.tens  <= sp5.digit;
			digits_s5.units <= sp5.rem[3:0];
		end
	end

	assign out_valid  = valid_s5;
	assign out_digits = digits_s5;

endmodule

[src/ttsf_frame_ser.sv]
// Serialiser that turns one set of digits into six display command bytes.
module ttsf_frame_ser
	import ttsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       colon_enable,
	input  logic       in_valid,
	output logic       in_ready,
	input  digits_t    in_digits,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] command_byte,
	output logic       frame_end,
	output logic       last
);

	typedef enum logic [2:0] {
		BEAT_DISPLAY,
		BEAT_ADDR,
		BEAT_THOU,
		BEAT_HUND,
		BEAT_TENS,
		BEAT_UNITS
	} beat_t;

	beat_t      beat_q;
	logic       busy_q;
	logic [7:0] seg_thou_q, seg_hund_q, seg_tens_q, seg_units_q;
	logic       take;

	// Load the next request as the final byte of the current one leaves.
	assign in_ready = !busy_q || (out_ready && (beat_q == BEAT_UNITS));
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			beat_q <= BEAT_DISPLAY;
		end else if (take) begin
			busy_q <= 1'b1;
			beat_q <= BEAT_DISPLAY;
		end else if (busy_q && out_ready) begin
			unique case (beat_q)
				BEAT_DISPLAY: beat_q <= BEAT_ADDR;
				BEAT_ADDR:    beat_q <= BEAT_THOU;
				BEAT_THOU:    beat_q <= BEAT_HUND;
				BEAT_HUND:    beat_q <= BEAT_TENS;
				BEAT_TENS:    beat_q <= BEAT_UNITS;
				BEAT_UNITS: begin
					busy_q <= 1'b0;
					beat_q <= BEAT_DISPLAY;
				end
				default:      beat_q <= BEAT_DISPLAY;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			seg_thou_q  <= seg_pattern(in_digits.thou);
			seg_hund_q  <= seg_pattern(in_digits.hund) | (colon_enable ? COLON_BIT : 8'h00);
			seg_tens_q  <= seg_pattern(in_digits.tens);
			seg_units_q <= seg_pattern(in_digits.units);
		end
	end

	always_comb begin
		frame_end = 1'b0;
		last      = 1'b0;
		unique case (beat_q)
			BEAT_DISPLAY: begin
				command_byte = CMD_DISPLAY;
				frame_end    = 1'b1;
			end
			BEAT_ADDR:    command_byte = CMD_ADDR;
			BEAT_THOU:    command_byte = seg_thou_q;
			BEAT_HUND:    command_byte = seg_hund_q;
			BEAT_TENS:    command_byte = seg_tens_q;
			BEAT_UNITS: begin
				command_byte = seg_units_q;
				frame_end    = 1'b1;
				last         = 1'b1;
			end
			default:      command_byte = CMD_DISPLAY;
		endcase
	end

	assign out_valid = busy_q;

endmodule

[src/temp_to_seven_segment_frames.sv]
// Top level: raw thermometer reading in, six display command bytes out.
//
// Input channel: one request carries reading_low and reading_high, the two raw
// bytes of the sensor word (bit 7 of the high byte is ignored). It is taken at
// a rising edge where in_valid and in_ready are both high.
// Output channel: each request yields six bytes in order: display command
// (frame_end), address command, then the thousands, hundreds (colon in bit 7
// when colon_enable is set), tens and units segment patterns; the units byte
// carries frame_end and last. A byte moves when out_valid and out_ready are high.
// Pipeline: five stages (offset and clamp, wrap to four digits, then one digit
// per stage) and one serialiser load; out_valid rises once the request has left
// the last stage and been loaded into the serialiser. Each request holds the
// single output byte lane for its six bytes; the pipeline takes a new request
// every cycle until it fills. When out_ready is low the current byte holds and
// the pipeline stages fill and then hold; nothing is lost or repeated. Reset
// clears every valid bit and sets colon_enable to 1. Configuration uses the APB
// port; write it only while idle.
module temp_to_seven_segment_frames
	import ttsf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            reading_low,
	input  logic [7:0]            reading_high,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            command_byte,
	output logic                  frame_end,
	output logic                  last
);

	logic    colon_enable_q;
	logic    cfg_write;
	logic    dig_valid;
	logic    dig_ready;
	digits_t dig_data;

	// Register index is the word address; only bit 0 of the data is kept.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colon_enable_q <= 1'b1;
		end else if (cfg_write && (paddr[2] == REG_COLON_ENABLE)) begin
			colon_enable_q <= pwdata[0];
		end
	end

	// Reads outside the register list return zero.
	assign prdata = (paddr[2] == REG_COLON_ENABLE) ?
		{{(CFG_DATA_W-1){1'b0}}, colon_enable_q} : '0;

	ttsf_digit_pipe u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.reading_low  (reading_low),
		.reading_high (reading_high),
		.out_valid    (dig_valid),
		.out_ready    (dig_ready),
		.out_digits   (dig_data)
	);

	ttsf_frame_ser u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.colon_enable (colon_enable_q),
		.in_valid     (dig_valid),
		.in_ready     (dig_ready),
		.in_digits    (dig_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.command_byte (command_byte),
		.frame_end    (frame_end),
		.last         (last)
	);

endmodule
